>>> hw/rtl/ccrt_pkg.sv
// Shared types, codes and window tables for the chamber climate relay timer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ccrt_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int DIFF_W     = 14;
	localparam int SPAN_W     = 34;
	localparam int REFRESH_MAX = 60;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP_OFF   = 3'd0,
		CFG_TEMP_HIGH  = 3'd1,
		CFG_HUM_OFF    = 3'd2,
		CFG_OVERRIDE   = 3'd3,
		CFG_FILTER_EN  = 3'd4,
		CFG_FAN_EN     = 3'd5,
		CFG_HEAT_SCALE = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CMD_OFF      = 3'd0,
		CMD_ON       = 3'd1,
		CMD_KEEP_ON  = 3'd2,
		CMD_KEEP_OFF = 3'd3,
		CMD_NONE     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		TZ_BELOW  = 2'd0,
		TZ_NORMAL = 2'd1,
		TZ_HIGH   = 2'd2
	} temp_zone_t;

	typedef logic [2:0] tier_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [SPAN_W-1:0] span_t;

	typedef struct packed {
		temp_zone_t tz;
		logic       hz;
		tier_t      heat_tier;
		tier_t      hum_tier;
		tier_t      fan_tier;
	} zone_info_t;

	localparam diff_t HEAT_LIM [4] = '{14'sd3, 14'sd8, 14'sd15, 14'sd20};
	localparam diff_t HUM_LIM  [4] = '{14'sd50, 14'sd100, 14'sd150, 14'sd200};
	localparam diff_t FAN_LIM  [4] = '{-14'sd20, -14'sd40, -14'sd60, -14'sd80};

	function automatic logic [7:0] heat_on_time(tier_t t);
		logic [7:0] r;
		case (t)
			3'd1, 3'd2, 3'd3, 3'd4, 3'd5: r = 8'd30;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] heat_off_time(tier_t t);
		logic [8:0] r;
		case (t)
			3'd1: r = 9'd300;
			3'd2: r = 9'd275;
			3'd3: r = 9'd250;
			3'd4: r = 9'd225;
			3'd5: r = 9'd200;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hum_on_time(tier_t t);
		logic [7:0] r;
		case (t)
			3'd1, 3'd2, 3'd3, 3'd4, 3'd5: r = 8'd45;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hum_off_time(tier_t t);
		logic [7:0] r;
		case (t)
			3'd1, 3'd2, 3'd3, 3'd4, 3'd5: r = 8'd60;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] filt_on_time(tier_t t);
		logic [7:0] r;
		case (t)
			3'd1: r = 8'd10;
			3'd2: r = 8'd20;
			3'd3: r = 8'd30;
			3'd4: r = 8'd40;
			3'd5: r = 8'd50;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] filt_off_time(tier_t t);
		logic [7:0] r;
		case (t)
			3'd1: r = 8'd20;
			3'd2: r = 8'd30;
			3'd3: r = 8'd40;
			3'd4: r = 8'd50;
			3'd5: r = 8'd55;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/ccrt_zone.sv
// Zone and tier classification of one reading against the thresholds.
// Depends on ccrt_pkg.
`timescale 1ns / 1ps

module ccrt_zone (
	input  logic signed [7:0]   temp_off_degrees,
	input  logic signed [7:0]   temp_high_degrees,
	input  logic [6:0]          hum_off_percent,
	input  logic signed [11:0]  temp_tenths,
	input  logic [9:0]          hum_tenths,
	output ccrt_pkg::zone_info_t info
);
	import ccrt_pkg::*;

	diff_t off10, high10, hoff10, temp, hum, tdiff, hdiff;

	assign off10  = DIFF_W'(temp_off_degrees) * 14'sd10;
	assign high10 = DIFF_W'(temp_high_degrees) * 14'sd10;
	assign hoff10 = $signed(DIFF_W'(hum_off_percent)) * 14'sd10;
	assign temp   = DIFF_W'(temp_tenths);
	assign hum    = $signed(DIFF_W'(hum_tenths));
	assign tdiff  = off10 - temp;
	assign hdiff  = hoff10 - hum;

	always_comb begin
		if (temp < off10)
			info.tz = TZ_BELOW;
		else if (temp < high10)
			info.tz = TZ_NORMAL;
		else
			info.tz = TZ_HIGH;
		info.hz = (hum < hoff10) ? 1'b0 : 1'b1;
		info.heat_tier = 3'd5;
		info.hum_tier  = 3'd5;
		info.fan_tier  = 3'd5;
		// scan from the last limit down so the lowest-index limit that matches wins
		for (int i = 3; i >= 0; i--) begin
			if (tdiff <= HEAT_LIM[i]) info.heat_tier = 3'(i + 1);
			if (hdiff < HUM_LIM[i])   info.hum_tier  = 3'(i + 1);
			if (tdiff > FAN_LIM[i])   info.fan_tier  = 3'(i + 1);
		end
	end

endmodule

>>> hw/rtl/ccrt_window.sv
// Timed on/off window decision for the heater and humidifier relays.
// Depends on ccrt_pkg.
`timescale 1ns / 1ps

module ccrt_window (
	input  ccrt_pkg::span_t elapsed,
	input  ccrt_pkg::span_t on_t,
	input  ccrt_pkg::span_t off_t,
	output ccrt_pkg::cmd_t  cmd,
	output ccrt_pkg::span_t cand
);
	import ccrt_pkg::*;

	always_comb begin
		if (elapsed - on_t < off_t) begin
			if (elapsed < on_t) begin
				cmd  = CMD_KEEP_ON;
				cand = on_t - elapsed;
			end else begin
				cmd  = CMD_KEEP_OFF;
				cand = off_t + on_t - elapsed;
			end
		end else begin
			cmd  = CMD_ON;
			cand = off_t;
		end
	end

endmodule

>>> hw/rtl/chamber_climate_relay_timer.sv
// Top level of the chamber climate relay timer: input register, decision
// logic, window start state and result register. Depends on ccrt_pkg,
// ccrt_zone and ccrt_window.
//
// Usage: each input request is one sensor reading (now_seconds, temp_tenths,
// hum_tenths), taken when in_valid is high and in_stall is low. Each reading
// yields exactly one result request carrying four relay commands, their on
// durations, the refresh interval and the two zones, offered on out_valid and
// taken when out_stall is low.
// Path: a reading goes from the input register into the result register,
// which drives out_valid; out_stall can hold it in the input register.
// Throughput: one reading per cycle while no held result stalls it; the whole
// decision is a single pass of compare and select logic plus one small
// multiply for the scaled heater off time.
// Window start times update at the edge a reading moves into the result
// register, so the next reading sees them at once.
// While out_stall is high the result holds; one more reading is held in the
// input register, after which in_stall rises.
// Reset zeroes the window starts, empties both registers and loads the
// configuration defaults. Configuration writes via cfg_wr_en/cfg_index/
// cfg_data are registered; the user must make them while idle (not enforced).
`timescale 1ns / 1ps

module chamber_climate_relay_timer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ccrt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ccrt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [31:0]                      now_seconds,
	input  logic signed [11:0]               temp_tenths,
	input  logic [9:0]                       hum_tenths,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       filter_cmd,
	output logic [7:0]                       filter_on_seconds,
	output logic [2:0]                       humid_cmd,
	output logic [7:0]                       humid_on_seconds,
	output logic [2:0]                       fan_cmd,
	output logic [7:0]                       fan_on_seconds,
	output logic [2:0]                       heat_cmd,
	output logic [7:0]                       heat_on_seconds,
	output logic [5:0]                       refresh_seconds,
	output logic [1:0]                       temp_zone,
	output logic                             hum_zone
);
	import ccrt_pkg::*;

	logic signed [7:0] temp_off_q, temp_high_q;
	logic [6:0]        hum_off_q;
	logic              override_q, filter_en_q, fan_en_q;
	logic [9:0]        heat_scale_q;

	logic [31:0] heat_start_q, humid_start_q, filter_start_q;

	logic               valid_s1;
	logic [31:0]        now_s1;
	logic signed [11:0] temp_s1;
	logic [9:0]         hum_s1;

	logic       valid_s2;
	cmd_t       fcmd_s2, mcmd_s2, ncmd_s2, hcmd_s2;
	logic [7:0] fon_s2, mon_s2, non_s2, hon_s2;
	logic [5:0] refresh_s2;
	logic [1:0] tz_s2;
	logic       hz_s2;

	logic advance;
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_off_q   <= 8'sd60;
			temp_high_q  <= 8'sd80;
			hum_off_q    <= 7'd40;
			override_q   <= 1'b0;
			filter_en_q  <= 1'b0;
			fan_en_q     <= 1'b0;
			heat_scale_q <= 10'd256;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TEMP_OFF:   temp_off_q   <= cfg_data[7:0];
				CFG_TEMP_HIGH:  temp_high_q  <= cfg_data[7:0];
				CFG_HUM_OFF:    hum_off_q    <= cfg_data[6:0];
				CFG_OVERRIDE:   override_q   <= cfg_data[0];
				CFG_FILTER_EN:  filter_en_q  <= cfg_data[0];
				CFG_FAN_EN:     fan_en_q     <= cfg_data[0];
				CFG_HEAT_SCALE: heat_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	zone_info_t zi;

	ccrt_zone u_zone (
		.temp_off_degrees  (temp_off_q),
		.temp_high_degrees (temp_high_q),
		.hum_off_percent   (hum_off_q),
		.temp_tenths       (temp_s1),
		.hum_tenths        (hum_s1),
		.info              (zi)
	);

	span_t heat_el, humid_el, filter_el;
	assign heat_el   = SPAN_W'($signed(now_s1 - heat_start_q));
	assign humid_el  = SPAN_W'($signed(now_s1 - humid_start_q));
	assign filter_el = SPAN_W'($signed(now_s1 - filter_start_q));

	logic [18:0] heat_off_prod;
	span_t       heat_on_t, heat_off_t, hum_on_t, hum_off_t;
	assign heat_off_prod = 19'(heat_off_time(zi.heat_tier)) * 19'(heat_scale_q);
	assign heat_on_t  = SPAN_W'(heat_on_time(zi.heat_tier));
	assign heat_off_t = SPAN_W'(heat_off_prod[18:8]);
	assign hum_on_t   = SPAN_W'(hum_on_time(zi.hum_tier));
	assign hum_off_t  = SPAN_W'(hum_off_time(zi.hum_tier));

	cmd_t  heat_wcmd, hum_wcmd;
	span_t heat_cand, hum_cand;

	ccrt_window u_heat_win (
		.elapsed (heat_el),
		.on_t    (heat_on_t),
		.off_t   (heat_off_t),
		.cmd     (heat_wcmd),
		.cand    (heat_cand)
	);

	ccrt_window u_hum_win (
		.elapsed (humid_el),
		.on_t    (hum_on_t),
		.off_t   (hum_off_t),
		.cmd     (hum_wcmd),
		.cand    (hum_cand)
	);

	cmd_t       fcmd, mcmd, ncmd, hcmd;
	logic [7:0] fon, mon, non, hon;
	span_t      refresh;
	span_t      filt_on_t, filt_off_t;
	logic       heat_load, humid_load, filter_load;

	assign filt_on_t  = SPAN_W'(filt_on_time(zi.fan_tier));
	assign filt_off_t = SPAN_W'(filt_off_time(zi.fan_tier));

	always_comb begin
		fcmd = CMD_NONE;
		mcmd = CMD_NONE;
		ncmd = CMD_NONE;
		hcmd = CMD_NONE;
		fon = 8'd0;
		mon = 8'd0;
		non = 8'd0;
		hon = 8'd0;
		refresh = SPAN_W'(REFRESH_MAX);
		heat_load = 1'b0;
		humid_load = 1'b0;
		filter_load = 1'b0;
		if (!override_q) begin
			if (filter_en_q) begin
				if (zi.tz == TZ_HIGH) begin
					if (filter_el < filt_off_t) begin
						if (filter_el < filt_on_t) begin
							fcmd = CMD_KEEP_ON;
							if (filt_on_t - filter_el < refresh) refresh = filt_on_t - filter_el;
						end else begin
							fcmd = CMD_KEEP_OFF;
							if (filt_off_t - filter_el < refresh)
								refresh = filt_off_t - filter_el;
						end
					end else begin
						fcmd = CMD_ON;
						fon = filt_on_time(zi.fan_tier);
						filter_load = 1'b1;
						if (filt_off_t < refresh) refresh = filt_off_t;
					end
				end else begin
					fcmd = CMD_OFF;
				end
			end
			if (!zi.hz) begin
				mcmd = hum_wcmd;
				if (hum_cand < refresh) refresh = hum_cand;
				case (hum_wcmd)
					CMD_ON: begin
						mon = hum_on_time(zi.hum_tier);
						humid_load = 1'b1;
						ncmd = CMD_ON;
					end
					CMD_KEEP_ON: ncmd = (zi.tz == TZ_BELOW) ? CMD_ON : CMD_NONE;
					default: ncmd = CMD_OFF;
				endcase
				if (ncmd == CMD_ON) non = hum_on_time(zi.hum_tier);
			end else begin
				mcmd = CMD_OFF;
				ncmd = CMD_OFF;
			end
			if (!fan_en_q) begin
				ncmd = CMD_NONE;
				non = 8'd0;
			end
			if (zi.tz == TZ_BELOW) begin
				hcmd = heat_wcmd;
				if (heat_cand < refresh) refresh = heat_cand;
				if (heat_wcmd == CMD_ON) begin
					hon = heat_on_time(zi.heat_tier);
					heat_load = 1'b1;
				end
			end else begin
				hcmd = CMD_OFF;
			end
			if (refresh <= 0) refresh = SPAN_W'(REFRESH_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_start_q   <= 32'd0;
			humid_start_q  <= 32'd0;
			filter_start_q <= 32'd0;
		end else if (advance) begin
			if (heat_load)   heat_start_q   <= now_s1;
			if (humid_load)  humid_start_q  <= now_s1;
			if (filter_load) filter_start_q <= now_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1  <= now_seconds;
			temp_s1 <= temp_tenths;
			hum_s1  <= hum_tenths;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fcmd_s2    <= fcmd;
			mcmd_s2    <= mcmd;
			ncmd_s2    <= ncmd;
			hcmd_s2    <= hcmd;
			fon_s2     <= fon;
			mon_s2     <= mon;
			non_s2     <= non;
			hon_s2     <= hon;
			refresh_s2 <= refresh[5:0];
			tz_s2      <= zi.tz;
			hz_s2      <= zi.hz;
		end
	end

	assign out_valid         = valid_s2;
	assign filter_cmd        = fcmd_s2;
	assign filter_on_seconds = fon_s2;
	assign humid_cmd         = mcmd_s2;
	assign humid_on_seconds  = mon_s2;
	assign fan_cmd           = ncmd_s2;
	assign fan_on_seconds    = non_s2;
	assign heat_cmd          = hcmd_s2;
	assign heat_on_seconds   = hon_s2;
	assign refresh_seconds   = refresh_s2;
	assign temp_zone         = tz_s2;
	assign hum_zone          = hz_s2;

endmodule

>>> tb/chamber_climate_relay_timer_tb.sv
`timescale 1ns / 1ps
// Testbench for chamber_climate_relay_timer: a scoreboard class predicts each relay
// result from every accepted reading and checks results in order of arrival.
// Depends on ccrt_pkg and the chamber_climate_relay_timer RTL.

module chamber_climate_relay_timer_tb;
	import ccrt_pkg::*;

	localparam int HEAT_TIER_LIM [4] = '{3, 8, 15, 20};
	localparam int HUM_TIER_LIM  [4] = '{50, 100, 150, 200};
	localparam int FAN_TIER_LIM  [4] = '{-20, -40, -60, -80};
	localparam int HEAT_ON_S     [6] = '{0, 30, 30, 30, 30, 30};
	localparam int HEAT_OFF_S    [6] = '{0, 300, 275, 250, 225, 200};
	localparam int HUM_ON_S      [6] = '{0, 45, 45, 45, 45, 45};
	localparam int HUM_OFF_S     [6] = '{0, 60, 60, 60, 60, 60};
	localparam int FILT_ON_S     [6] = '{0, 10, 20, 30, 40, 50};
	localparam int FILT_OFF_S    [6] = '{0, 20, 30, 40, 50, 55};
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct packed {
		cmd_t       filter_cmd;
		logic [7:0] filter_on;
		cmd_t       humid_cmd;
		logic [7:0] humid_on;
		cmd_t       fan_cmd;
		logic [7:0] fan_on;
		cmd_t       heat_cmd;
		logic [7:0] heat_on;
		logic [5:0] refresh;
		temp_zone_t tz;
		logic       hz;
	} relay_result_t;

	class relay_scoreboard;
		int temp_off, temp_high, hum_off, heat_scale;
		bit override, filter_en, fan_en;
		logic [31:0] heat_start, humid_start, filter_start;
		relay_result_t pending [$];
		int errors, readings, turn_ons;
		int zone_hits [3];

		function new();
			temp_off = 60;
			temp_high = 80;
			hum_off = 40;
			heat_scale = 256;
			override = 1'b0;
			filter_en = 1'b0;
			fan_en = 1'b0;
			heat_start = '0;
			humid_start = '0;
			filter_start = '0;
			errors = 0;
			readings = 0;
			turn_ons = 0;
			zone_hits = '{0, 0, 0};
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TEMP_OFF:   temp_off = $signed(data[7:0]);
				CFG_TEMP_HIGH:  temp_high = $signed(data[7:0]);
				CFG_HUM_OFF:    hum_off = data[6:0];
				CFG_OVERRIDE:   override = data[0];
				CFG_FILTER_EN:  filter_en = data[0];
				CFG_FAN_EN:     fan_en = data[0];
				CFG_HEAT_SCALE: heat_scale = data[9:0];
				default: ;
			endcase
		endfunction

		function longint since(logic [31:0] now, logic [31:0] start);
			logic [31:0] d;
			d = now - start;
			return longint'($signed(d));
		endfunction

		function cmd_t run_window(longint e, longint on_t, longint off_t, output longint cand);
			if (e - on_t < off_t) begin
				if (e < on_t) begin
					cand = on_t - e;
					return CMD_KEEP_ON;
				end
				cand = off_t + on_t - e;
				return CMD_KEEP_OFF;
			end
			cand = off_t;
			return CMD_ON;
		endfunction

		function void note_reading(logic [31:0] now, logic signed [11:0] temp, logic [9:0] hum);
			relay_result_t r;
			int tv, hv, off10, high10, tdiff, hdiff, ht, mt, ft, i;
			longint e, on_t, off_t, cand, refresh;
			tv = temp;
			hv = hum;
			off10 = temp_off * 10;
			high10 = temp_high * 10;
			tdiff = off10 - tv;
			hdiff = hum_off * 10 - hv;
			r = '0;
			r.filter_cmd = CMD_NONE;
			r.humid_cmd = CMD_NONE;
			r.fan_cmd = CMD_NONE;
			r.heat_cmd = CMD_NONE;
			refresh = REFRESH_MAX;
			r.tz = (tv < off10) ? TZ_BELOW : ((tv < high10) ? TZ_NORMAL : TZ_HIGH);
			r.hz = (hv >= hum_off * 10);
			ht = 5;
			mt = 5;
			ft = 5;
			for (i = 0; i < 4; i++) if (tdiff <= HEAT_TIER_LIM[i]) begin
				ht = i + 1;
				break;
			end
			for (i = 0; i < 4; i++) if (hdiff < HUM_TIER_LIM[i]) begin
				mt = i + 1;
				break;
			end
			for (i = 0; i < 4; i++) if (tdiff > FAN_TIER_LIM[i]) begin
				ft = i + 1;
				break;
			end

			if (!override) begin
				if (filter_en) begin
					if (r.tz == TZ_HIGH) begin
						e = since(now, filter_start);
						on_t = FILT_ON_S[ft];
						off_t = FILT_OFF_S[ft];
						if (e < off_t) begin
							if (e < on_t) begin
								r.filter_cmd = CMD_KEEP_ON;
								cand = on_t - e;
							end else begin
								r.filter_cmd = CMD_KEEP_OFF;
								cand = off_t - e;
							end
						end else begin
							r.filter_cmd = CMD_ON;
							r.filter_on = 8'(on_t);
							cand = off_t;
							filter_start = now;
						end
						if (cand < refresh) refresh = cand;
					end else begin
						r.filter_cmd = CMD_OFF;
					end
				end

				// fan follows the humidifier window
				if (!r.hz) begin
					on_t = HUM_ON_S[mt];
					r.humid_cmd = run_window(since(now, humid_start), on_t, HUM_OFF_S[mt], cand);
					if (cand < refresh) refresh = cand;
					case (r.humid_cmd)
						CMD_ON: begin
							r.humid_on = 8'(on_t);
							humid_start = now;
							r.fan_cmd = CMD_ON;
						end
						CMD_KEEP_ON: r.fan_cmd = (r.tz == TZ_BELOW) ? CMD_ON : CMD_NONE;
						default: r.fan_cmd = CMD_OFF;
					endcase
					if (r.fan_cmd == CMD_ON) r.fan_on = 8'(on_t);
				end else begin
					r.humid_cmd = CMD_OFF;
					r.fan_cmd = CMD_OFF;
				end
				if (!fan_en) begin
					r.fan_cmd = CMD_NONE;
					r.fan_on = '0;
				end

				if (r.tz == TZ_BELOW) begin
					on_t = HEAT_ON_S[ht];
					off_t = (longint'(HEAT_OFF_S[ht]) * heat_scale) >> 8;
					r.heat_cmd = run_window(since(now, heat_start), on_t, off_t, cand);
					if (cand < refresh) refresh = cand;
					if (r.heat_cmd == CMD_ON) begin
						r.heat_on = 8'(on_t);
						heat_start = now;
					end
				end else begin
					r.heat_cmd = CMD_OFF;
				end
				if (refresh <= 0) refresh = REFRESH_MAX;
			end
			r.refresh = 6'(refresh);

			pending.push_back(r);
			readings++;
			zone_hits[r.tz]++;
			turn_ons += int'(r.filter_cmd == CMD_ON) + int'(r.humid_cmd == CMD_ON)
				+ int'(r.fan_cmd == CMD_ON) + int'(r.heat_cmd == CMD_ON);
		endfunction

		function void check_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(relay_result_t got);
			relay_result_t want;
			if (pending.size() == 0) begin
				$error("result request with no reading outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			check_field("filter_cmd", want.filter_cmd, got.filter_cmd);
			check_field("filter_on_seconds", want.filter_on, got.filter_on);
			check_field("humid_cmd", want.humid_cmd, got.humid_cmd);
			check_field("humid_on_seconds", want.humid_on, got.humid_on);
			check_field("fan_cmd", want.fan_cmd, got.fan_cmd);
			check_field("fan_on_seconds", want.fan_on, got.fan_on);
			check_field("heat_cmd", want.heat_cmd, got.heat_cmd);
			check_field("heat_on_seconds", want.heat_on, got.heat_on);
			check_field("refresh_seconds", want.refresh, got.refresh);
			check_field("temp_zone", want.tz, got.tz);
			check_field("hum_zone", want.hz, got.hz);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [31:0]           now_seconds = '0;
	logic signed [11:0]    temp_tenths = '0;
	logic [9:0]            hum_tenths = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            filter_cmd, humid_cmd, fan_cmd, heat_cmd;
	logic [7:0]            filter_on_seconds, humid_on_seconds, fan_on_seconds, heat_on_seconds;
	logic [5:0]            refresh_seconds;
	logic [1:0]            temp_zone;
	logic                  hum_zone;

	relay_scoreboard sb;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit hold_request = 1'b0;
	int settings = 0;

	chamber_climate_relay_timer u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.now_seconds       (now_seconds),
		.temp_tenths       (temp_tenths),
		.hum_tenths        (hum_tenths),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.filter_cmd        (filter_cmd),
		.filter_on_seconds (filter_on_seconds),
		.humid_cmd         (humid_cmd),
		.humid_on_seconds  (humid_on_seconds),
		.fan_cmd           (fan_cmd),
		.fan_on_seconds    (fan_on_seconds),
		.heat_cmd          (heat_cmd),
		.heat_on_seconds   (heat_on_seconds),
		.refresh_seconds   (refresh_seconds),
		.temp_zone         (temp_zone),
		.hum_zone          (hum_zone)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_cfg(int to, int th, int ho, int ov, int fe, int fa, int sc);
		cfg_idx_t regs [7];
		logic [CFG_DATA_W-1:0] vals [7];
		regs = '{CFG_TEMP_OFF, CFG_TEMP_HIGH, CFG_HUM_OFF, CFG_OVERRIDE,
			CFG_FILTER_EN, CFG_FAN_EN, CFG_HEAT_SCALE};
		vals = '{10'(to) & 10'h0FF, 10'(th) & 10'h0FF, 10'(ho), 10'(ov),
			10'(fe), 10'(fa), 10'(sc)};
		settle();
		for (int i = 0; i < 7; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			sb.write_reg(regs[i], vals[i]);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	task automatic send_reading(logic [31:0] now, int temp, int hum);
		int gap;
		gap = send_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_seconds <= now;
		temp_tenths <= 12'(temp);
		hum_tenths <= 10'(hum);
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		sb.note_reading(now, 12'(temp), 10'(hum));
	endtask

	task automatic run_random(int count, bit with_hold);
		logic [31:0] now;
		int temp, hum, kind, base;
		now = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255)) : $urandom;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			if (i == 0 && with_hold) begin
				send_idle = 1'b0;
				hold_request = 1'b1;
			end
			kind = $urandom_range(0, 15);
			if (kind == 0) begin
				// jump anywhere in time, reading anywhere in range
				now = $urandom;
				temp = int'($urandom_range(0, 1650)) - 400;
				hum = $urandom_range(0, 1000);
			end else begin
				now = now + ((kind == 1) ? $urandom_range(60, 400) : $urandom_range(0, 25));
				base = ($urandom_range(0, 2) == 0) ? sb.temp_high * 10 : sb.temp_off * 10;
				temp = clamp(base + int'($urandom_range(0, 240)) - 120, -400, 1250);
				hum = clamp(sb.hum_off * 10 + 40 - int'($urandom_range(0, 280)), 0, 1000);
			end
			send_reading(now, temp, hum);
		end
	endtask

	initial begin : result_side
		relay_result_t got;
		int wait_cycles;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = recv_idle ? $urandom_range(0, 7) : 0;
			if (hold_request) begin
				hold_request = 1'b0;
				wait_cycles = HOLD_CYCLES;
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			got = '{cmd_t'(filter_cmd), filter_on_seconds, cmd_t'(humid_cmd), humid_on_seconds,
				cmd_t'(fan_cmd), fan_on_seconds, cmd_t'(heat_cmd), heat_on_seconds,
				refresh_seconds, temp_zone_t'(temp_zone), hum_zone};
			sb.check_result(got);
		end
	end

	initial begin
		#(5_000_000);
		$display("chamber_climate_relay_timer_tb: errors");
		$finish;
	end

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all relays driven, default thresholds
		apply_cfg(60, 80, 40, 0, 1, 1, 256);
		send_reading(32'd0, -400, 0);
		send_reading(32'd100, 500, 0);
		send_reading(32'd400, 598, 399);
		send_reading(32'd410, 1250, 1000);
		send_reading(32'd420, 800, 400);
		send_reading(32'd470, 799, 399);
		send_reading(32'hFFFF_FFFF, 0, 500);
		send_reading(32'h8000_0000, 585, 250);
		send_reading(32'h0000_0010, 1250, 1000);
		send_reading(32'h0000_0040, 600, 0);

		// zero heater scale
		apply_cfg(60, 80, 40, 0, 1, 1, 0);
		send_reading(32'h1000_0000, 590, 300);
		send_reading(32'h1000_0010, 590, 300);
		send_reading(32'h1000_0100, -400, 1000);

		// manual override freezes every relay
		apply_cfg(60, 80, 40, 1, 1, 1, 1023);
		send_reading(32'h2000_0000, -400, 0);
		send_reading(32'h2000_0005, 1250, 1000);

		// off threshold above high threshold
		apply_cfg(50, 20, 100, 0, 1, 1, 1023);
		send_reading(32'h3000_0000, 500, 999);
		send_reading(32'h3000_0004, 499, 1000);
		send_reading(32'h3000_0040, 200, 0);

		// filter and fan released to manual control
		apply_cfg(-40, 125, 0, 0, 0, 0, 256);
		send_reading(32'h4000_0000, 1250, 0);
		send_reading(32'h4000_0008, -400, 1000);

		apply_cfg(60, 80, 40, 0, 1, 1, 256);
		run_random(220, 1'b1);
		apply_cfg(-40, 125, 0, 0, 1, 1, 1023);
		run_random(220, 1'b0);
		apply_cfg(125, -40, 100, 0, 1, 1, 0);
		run_random(220, 1'b0);
		apply_cfg(25, 27, 55, 0, 1, 0, 128);
		run_random(220, 1'b0);
		apply_cfg(30, 30, 70, 0, 0, 1, 512);
		run_random(220, 1'b0);
		apply_cfg(20, 40, 50, 1, 1, 1, 300);
		run_random(100, 1'b0);
		repeat (2) begin
			apply_cfg(int'($urandom_range(0, 165)) - 40, int'($urandom_range(0, 165)) - 40,
				$urandom_range(0, 100), ($urandom_range(0, 5) == 0), $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1023));
			run_random(220, 1'b0);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d readings under %0d register settings, %0d relay turn-on commands.",
			sb.readings, settings, sb.turn_ons);
		$display("Temperature zones seen: below %0d, normal %0d, high %0d.",
			sb.zone_hits[TZ_BELOW], sb.zone_hits[TZ_NORMAL], sb.zone_hits[TZ_HIGH]);
		if (sb.errors == 0) begin
			$display("chamber_climate_relay_timer_tb: clean");
		end else begin
			$display("chamber_climate_relay_timer_tb: errors");
		end
		$finish;
	end

endmodule
